// ----- rtl/core/sra_pkg.sv -----
// ---------------------------------------------------------------------------
// sra_pkg
// Shared types and constants of the signed radix to text converter: controller
// states, command and status bundles, character codes and register indexes.
// ---------------------------------------------------------------------------
package sra_pkg;

   // widths fixed by the register map and the result format
   localparam int CHAR_W      = 8;
   localparam int RADIX_W     = 6;
   localparam int DIGIT_W     = 5;
   localparam int ALPHA_SLOTS = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int DIV_BITS    = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RADIX  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA3 = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // smallest usable radix
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

   // result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FAIL,
      ST_DIV,
      ST_SIGN,
      ST_EMIT,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic check_step;
      logic emit_err;
      logic div_step;
      logic emit_sign;
      logic emit_read;
   } sra_cmd_type;

   typedef struct packed {
      logic alpha_bad;
      logic check_last;
      logic div_last;
      logic div_stop;
      logic neg;
      logic emit_last;
      logic pipe_idle;
   } sra_status_type;

endpackage

// ----- rtl/core/sra_ctrl.sv -----
// ---------------------------------------------------------------------------
// sra_ctrl
// Sequencer of the converter: alphabet check, digit division, sign and
// digit emission, each phase driven through commands to the datapath.
// ---------------------------------------------------------------------------
module sra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output sra_pkg::sra_cmd_type    cmd,
   input  sra_pkg::sra_status_type status
);

   sra_pkg::ctrl_state_type state_ff;
   sra_pkg::ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sra_pkg::ST_IDLE: begin
            if (start) state_in = sra_pkg::ST_CHECK;
         end
         sra_pkg::ST_CHECK: begin
            if (status.alpha_bad) begin
               state_in = sra_pkg::ST_FAIL;
            end else if (status.check_last) begin
               state_in = sra_pkg::ST_DIV;
            end
         end
         sra_pkg::ST_FAIL: begin
            state_in = sra_pkg::ST_IDLE;
         end
         sra_pkg::ST_DIV: begin
            if (status.div_last && status.div_stop) begin
               state_in = status.neg ? sra_pkg::ST_SIGN : sra_pkg::ST_EMIT;
            end
         end
         sra_pkg::ST_SIGN: begin
            state_in = sra_pkg::ST_EMIT;
         end
         sra_pkg::ST_EMIT: begin
            if (status.emit_last) state_in = sra_pkg::ST_DRAIN;
         end
         sra_pkg::ST_DRAIN: begin
            if (status.pipe_idle) state_in = sra_pkg::ST_IDLE;
         end
         default: begin
            state_in = sra_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      busy           = (state_ff != sra_pkg::ST_IDLE);
      cmd.load       = (state_ff == sra_pkg::ST_IDLE) && start;
      cmd.check_step = (state_ff == sra_pkg::ST_CHECK);
      cmd.emit_err   = (state_ff == sra_pkg::ST_FAIL);
      cmd.div_step   = (state_ff == sra_pkg::ST_DIV);
      cmd.emit_sign  = (state_ff == sra_pkg::ST_SIGN);
      cmd.emit_read  = (state_ff == sra_pkg::ST_EMIT);
   end

`ifndef SYNTH
   // an accepted item always opens with the alphabet check
   a_start_to_check: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == sra_pkg::ST_CHECK)
      else $error("accepted item did not enter the alphabet check");

   // the digit phase is only left once the quotient is exhausted or the digit buffer is full
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == sra_pkg::ST_DIV && !(status.div_last && status.div_stop)
      |=> state_ff == sra_pkg::ST_DIV)
      else $error("division phase left early");
`endif

endmodule

// ----- rtl/core/sra_dpath.sv -----
// ---------------------------------------------------------------------------
// sra_dpath
// Datapath of the converter: configuration registers, alphabet checker,
// digit divider (eight quotient bits per cycle), digit buffer and the
// registered result stage.
// ---------------------------------------------------------------------------
module sra_dpath #(
   parameter int MAX_DIGITS = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sra_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sra_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic signed [VALUE_BITS-1:0]         req_number,
   input  sra_pkg::sra_cmd_type                 cmd,
   output sra_pkg::sra_status_type              status,
   output logic                                 rsp_valid,
   output logic [sra_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                 rsp_last,
   output logic                                 rsp_status
);

   localparam int STEPS  = (VALUE_BITS + sra_pkg::DIV_BITS - 1) / sra_pkg::DIV_BITS;
   localparam int QW     = STEPS * sra_pkg::DIV_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W  = $clog2(MAX_DIGITS);
   localparam int SLOT_W = $clog2(sra_pkg::ALPHA_SLOTS);

   // configuration
   logic [sra_pkg::RADIX_W-1:0]                      radix_ff;
   logic [sra_pkg::ALPHA_SLOTS-1:0][sra_pkg::CHAR_W-1:0] alpha_ff;

   // working registers
   logic                         neg_ff, neg_in;
   logic [QW-1:0]                magnitude_ff, magnitude_in;
   logic [sra_pkg::DIGIT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [CNT_W-1:0]             digit_total_ff, digit_total_in;
   logic [SLOT_W-1:0]            chk_ff, chk_in;
   logic [IDX_W-1:0]             rd_ptr_ff, rd_ptr_in;

   // digit buffer and read pipeline
   logic [sra_pkg::DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
   logic [sra_pkg::DIGIT_W-1:0]  rd_data_ff;
   logic                         pend_ff;
   logic                         pend_last_ff;

   // result registers
   logic                         rsp_valid_ff;
   logic [sra_pkg::CHAR_W-1:0]   rsp_character_ff;
   logic                         rsp_last_ff;
   logic                         rsp_status_ff;

   // combinational helpers
   logic [VALUE_BITS-1:0]        raw_mag;
   logic [sra_pkg::CHAR_W-1:0]   cur_char;
   logic                         char_bad;
   logic                         dup_found;
   logic                         radix_bad;
   logic [sra_pkg::RADIX_W-1:0]  radix_top;
   logic [sra_pkg::DIV_BITS-1:0] div_top;
   logic [sra_pkg::DIV_BITS-1:0] qbits;
   logic [sra_pkg::DIGIT_W-1:0]  rem_next;
   logic [QW+sra_pkg::DIV_BITS-1:0] shifted;
   logic [QW-1:0]                quot_next;
   logic                         div_last;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
         alpha_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sra_pkg::REG_RADIX:  radix_ff <= csr_data[sra_pkg::RADIX_W-1:0];
            sra_pkg::REG_ALPHA0: alpha_ff[0  +: 8] <= csr_data;
            sra_pkg::REG_ALPHA1: alpha_ff[8  +: 8] <= csr_data;
            sra_pkg::REG_ALPHA2: alpha_ff[16 +: 8] <= csr_data;
            sra_pkg::REG_ALPHA3: alpha_ff[24 +: 8] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // magnitude of the incoming value
   assign raw_mag = req_number[VALUE_BITS-1] ? (~req_number + 1'b1) : req_number;

   // alphabet check, one character against all later ones per cycle
   assign radix_top = radix_ff - 1'b1;
   assign radix_bad = (radix_ff < sra_pkg::RADIX_MIN) ||
                      (radix_ff > sra_pkg::RADIX_W'(sra_pkg::ALPHA_SLOTS));
   assign cur_char  = alpha_ff[chk_ff];
   assign char_bad  = (cur_char == sra_pkg::CHAR_NUL)   || (cur_char == sra_pkg::CHAR_PLUS) ||
                      (cur_char == sra_pkg::CHAR_MINUS) || (cur_char == sra_pkg::CHAR_SPACE) ||
                      ((cur_char >= sra_pkg::CHAR_TAB) && (cur_char <= sra_pkg::CHAR_CR));

   always_comb begin
      dup_found = 1'b0;
      for (int j = 0; j < sra_pkg::ALPHA_SLOTS; j++) begin
         if ((SLOT_W'(j) > chk_ff) && (sra_pkg::RADIX_W'(j) < radix_ff) &&
             (alpha_ff[j] == cur_char)) begin
            dup_found = 1'b1;
         end
      end
   end

   // one divider step: eight restoring quotient bits
   assign div_top = magnitude_ff[QW-1 -: sra_pkg::DIV_BITS];

   always_comb begin
      logic [sra_pkg::RADIX_W-1:0] trial;
      logic [sra_pkg::DIGIT_W-1:0] rem_v;
      rem_v = rem_ff;
      qbits = '0;
      for (int b = sra_pkg::DIV_BITS - 1; b >= 0; b--) begin
         trial = {rem_v, div_top[b]};
         if (trial >= radix_ff) begin
            rem_v    = sra_pkg::DIGIT_W'(trial - radix_ff);
            qbits[b] = 1'b1;
         end else begin
            rem_v    = trial[sra_pkg::DIGIT_W-1:0];
         end
      end
      rem_next = rem_v;
   end

   assign shifted   = {magnitude_ff, qbits};
   assign quot_next = shifted[QW-1:0];
   assign div_last  = (step_ff == STEP_W'(STEPS - 1));

   // status to the controller
   always_comb begin
      status            = '0;
      status.alpha_bad  = radix_bad || char_bad || dup_found;
      status.check_last = ({1'b0, chk_ff} == radix_top);
      status.div_last   = div_last;
      status.div_stop   = (quot_next == '0) || (digit_total_ff == CNT_W'(MAX_DIGITS - 1));
      status.neg        = neg_ff;
      status.emit_last  = (rd_ptr_ff == '0);
      status.pipe_idle  = !pend_ff;
   end

   // next values of the working registers
   always_comb begin
      neg_in         = neg_ff;
      magnitude_in   = magnitude_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      digit_total_in = digit_total_ff;
      chk_in         = chk_ff;
      rd_ptr_in      = rd_ptr_ff;
      if (cmd.load) begin
         neg_in         = req_number[VALUE_BITS-1];
         magnitude_in   = QW'(raw_mag);
         rem_in         = '0;
         step_in        = '0;
         digit_total_in = '0;
         chk_in         = '0;
      end
      if (cmd.check_step) begin
         chk_in = chk_ff + 1'b1;
      end
      if (cmd.div_step) begin
         magnitude_in = quot_next;
         if (div_last) begin
            rem_in         = '0;
            step_in        = '0;
            digit_total_in = digit_total_ff + 1'b1;
            rd_ptr_in      = digit_total_ff[IDX_W-1:0];
         end else begin
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
         end
      end
      if (cmd.emit_read) begin
         rd_ptr_in = rd_ptr_ff - 1'b1;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_total_ff <= '0;
         step_ff        <= '0;
         chk_ff         <= '0;
         rd_ptr_ff      <= '0;
      end else begin
         digit_total_ff <= digit_total_in;
         step_ff        <= step_in;
         chk_ff         <= chk_in;
         rd_ptr_ff      <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      magnitude_ff <= magnitude_in;
      rem_ff       <= rem_in;
   end

   // digit buffer, least significant digit first
   always_ff @(posedge clock) begin
      if (cmd.div_step && div_last) begin
         digit_mem[digit_total_ff[IDX_W-1:0]] <= rem_next;
      end
      if (cmd.emit_read) begin
         rd_data_ff <= digit_mem[rd_ptr_ff];
      end
   end

   // read pipeline flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.emit_read;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= (rd_ptr_ff == '0);
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pend_ff || cmd.emit_sign || cmd.emit_err;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.emit_err) begin
         rsp_character_ff <= sra_pkg::CHAR_NUL;
         rsp_last_ff      <= 1'b1;
         rsp_status_ff    <= sra_pkg::STATUS_ERR;
      end else if (cmd.emit_sign) begin
         rsp_character_ff <= sra_pkg::CHAR_MINUS;
         rsp_last_ff      <= 1'b0;
         rsp_status_ff    <= sra_pkg::STATUS_OK;
      end else begin
         rsp_character_ff <= alpha_ff[rd_data_ff];
         rsp_last_ff      <= pend_last_ff;
         rsp_status_ff    <= sra_pkg::STATUS_OK;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTH
   // an error item is always the only and last one
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == sra_pkg::STATUS_ERR)
      |-> rsp_last_ff && (rsp_character_ff == sra_pkg::CHAR_NUL))
      else $error("error item not marked last or not zero");

   // nothing of the conversion is still in flight after its last item
   a_no_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !pend_ff)
      else $error("digit read still pending after last item");

   // digit count stays within the buffer
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      digit_total_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond buffer depth");
`endif

endmodule

// ----- rtl/core/signed_radix_to_ascii.sv -----
// ---------------------------------------------------------------------------
// signed_radix_to_ascii
// Converts a signed value into its text form in a configurable base.
// ---------------------------------------------------------------------------
// Usage: load the radix (index 0) and the alphabet words (indexes 1 to 4)
// through the csr port while busy is low. Raise start with req_number; the
// item is taken at a clock edge where start is high and busy is low.
// Results leave byte by byte on rsp_character, marked by rsp_valid,
// most significant digit first, with a leading '-' for negative values and
// rsp_last on the final byte. A bad alphabet gives one item with rsp_status
// set, character zero and rsp_last set.
// Sequence: the alphabet check walks the used characters (it fails on the first
// check when the radix is out of range), each digit is formed by the shared
// eight-bit-per-cycle divider, then comes the sign, and the digits stream out
// one per cycle from the digit buffer through rd_data_ff and the result
// registers; busy stays high until the last item has been presented.
// Reset clears the configuration to zero and returns the sequencer to idle.
// The receiver cannot stall: every item is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module signed_radix_to_ascii #(
   parameter int MAX_DIGITS = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [sra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sra_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [VALUE_BITS-1:0]    req_number,
   output logic                            rsp_valid,
   output logic [sra_pkg::CHAR_W-1:0]      rsp_character,
   output logic                            rsp_last,
   output logic                            rsp_status
);

   sra_pkg::sra_cmd_type    cmd;
   sra_pkg::sra_status_type status;

   // sequencer
   sra_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // datapath
   sra_dpath #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_number       (req_number),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

endmodule

// ----- test/signed_radix_to_ascii_tb.sv -----
// ---------------------------------------------------------------------------
// signed_radix_to_ascii_tb
// Drives signed values through the radix-to-text converter under directed
// and random alphabet settings, predicts every text byte in the testbench
// and checks each strobed result against the oldest pending prediction.
// ---------------------------------------------------------------------------
module signed_radix_to_ascii_tb;

   localparam int MAX_DIGITS = 32;
   localparam int VALUE_BITS = 32;
   localparam int STALL_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [sra_pkg::CHAR_W-1:0] character;
      logic                       last;
      logic                       status;
   } text_byte_type;

   typedef logic [sra_pkg::CSR_DATA_W-1:0] word_set_type [4];

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_enable = 1'b0;
   logic [sra_pkg::CSR_INDEX_W-1:0]   csr_index = sra_pkg::REG_RADIX;
   logic [sra_pkg::CSR_DATA_W-1:0]    csr_data = '0;
   logic                              start = 1'b0;
   logic                              busy;
   logic signed [VALUE_BITS-1:0]      req_number = '0;
   logic                              rsp_valid;
   logic [sra_pkg::CHAR_W-1:0]        rsp_character;
   logic                              rsp_last;
   logic                              rsp_status;

   // converter model state
   logic [sra_pkg::RADIX_W-1:0]    radix_setting = '0;
   logic [sra_pkg::CSR_DATA_W-1:0] alphabet_words [4] = '{default: '0};

   text_byte_type pending_text [$];
   int            mismatch_count = 0;
   int            stall_cycles = 0;
   bit            steady_stream = 1'b0;

   signed_radix_to_ascii #(
      .MAX_DIGITS(MAX_DIGITS),
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .start(start),
      .busy(busy),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // text prediction
   // ------------------------------------------------------------------
   function automatic logic [sra_pkg::CHAR_W-1:0] alpha_byte(int slot);
      return alphabet_words[slot / 8][(slot % 8) * 8 +: sra_pkg::CHAR_W];
   endfunction

   function automatic bit byte_usable(logic [sra_pkg::CHAR_W-1:0] c);
      return !(c == sra_pkg::CHAR_NUL || c == sra_pkg::CHAR_PLUS ||
               c == sra_pkg::CHAR_MINUS || c == sra_pkg::CHAR_SPACE ||
               (c >= sra_pkg::CHAR_TAB && c <= sra_pkg::CHAR_CR));
   endfunction

   function automatic bit alphabet_valid();
      int n;
      n = radix_setting;
      if (n < sra_pkg::RADIX_MIN || n > sra_pkg::ALPHA_SLOTS)
         return 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!byte_usable(alpha_byte(i)))
            return 1'b0;
         for (int j = i + 1; j < n; j++)
            if (alpha_byte(j) == alpha_byte(i))
               return 1'b0;
      end
      return 1'b1;
   endfunction

   // queue up the text bytes one value turns into
   function automatic void predict_text(logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0]        mag;
      logic [VALUE_BITS-1:0]        base;
      logic [sra_pkg::DIGIT_W-1:0]  digits [MAX_DIGITS];
      int                           digit_count;
      bit                           neg;
      text_byte_type                entry;
      if (!alphabet_valid()) begin
         entry = '{sra_pkg::CHAR_NUL, 1'b1, sra_pkg::STATUS_ERR};
         pending_text.push_back(entry);
         return;
      end
      neg = value[VALUE_BITS-1];
      mag = neg ? -value : value;
      base = radix_setting;
      digit_count = 0;
      // least significant digit first
      do begin
         digits[digit_count] = sra_pkg::DIGIT_W'(mag % base);
         digit_count++;
         mag = mag / base;
      end while (mag != 0 && digit_count < MAX_DIGITS);
      if (neg) begin
         entry = '{sra_pkg::CHAR_MINUS, 1'b0, sra_pkg::STATUS_OK};
         pending_text.push_back(entry);
      end
      for (int d = digit_count - 1; d >= 0; d--) begin
         entry = '{alpha_byte(digits[d]), d == 0, sra_pkg::STATUS_OK};
         pending_text.push_back(entry);
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   // distinct usable bytes in use, arbitrary bytes in the unused slots
   function automatic word_set_type make_alphabet(int n);
      word_set_type               w;
      logic [sra_pkg::CHAR_W-1:0] c;
      bit                         taken [256];
      for (int i = 0; i < sra_pkg::ALPHA_SLOTS; i++) begin
         if (i < n) begin
            do c = sra_pkg::CHAR_W'($urandom); while (!byte_usable(c) || taken[c]);
            taken[c] = 1'b1;
         end else begin
            c = sra_pkg::CHAR_W'($urandom);
         end
         w[i / 8][(i % 8) * 8 +: sra_pkg::CHAR_W] = c;
      end
      return w;
   endfunction

   // consecutive characters starting at first_char, zero elsewhere
   function automatic word_set_type run_alphabet(logic [sra_pkg::CHAR_W-1:0] first_char,
                                                 int n);
      word_set_type w;
      w = '{default: '0};
      for (int i = 0; i < n; i++)
         w[i / 8][(i % 8) * 8 +: sra_pkg::CHAR_W] = first_char + sra_pkg::CHAR_W'(i);
      return w;
   endfunction

   function automatic logic [sra_pkg::CHAR_W-1:0] random_bad_char();
      int unsigned pick;
      pick = $urandom_range(0, 8);
      case (pick)
         0: return sra_pkg::CHAR_NUL;
         1: return sra_pkg::CHAR_PLUS;
         2: return sra_pkg::CHAR_MINUS;
         3: return sra_pkg::CHAR_SPACE;
         default: return sra_pkg::CHAR_TAB + sra_pkg::CHAR_W'(pick - 4);
      endcase
   endfunction

   function automatic int random_radix();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return 2;
      if (pick < 40) return sra_pkg::ALPHA_SLOTS;
      if (pick < 45) return 10;
      if (pick < 50) return 16;
      return $urandom_range(sra_pkg::RADIX_MIN, sra_pkg::ALPHA_SLOTS);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] random_number();
      int unsigned           pick;
      logic [VALUE_BITS-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         v = $urandom;
      end else if (pick < 80) begin
         v = $urandom >> $urandom_range(1, 31);
         if ($urandom_range(0, 1)) v = -v;
      end else if (pick < 90) begin
         v = int'($urandom_range(0, 40)) - 20;
      end else begin
         case ($urandom_range(0, 3))
            0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
            1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
            2: v = '0;
            default: v = '1;
         endcase
      end
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch: %s", msg);
   endtask

   // wait until every pending byte has come out and the block is idle
   task automatic drain_pending();
      start <= 1'b0;
      do @(posedge clock); while (pending_text.size() != 0 || busy);
   endtask

   task automatic write_csr(logic [sra_pkg::CSR_INDEX_W-1:0] index,
                            logic [sra_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      case (index)
         sra_pkg::REG_RADIX:  radix_setting = data[sra_pkg::RADIX_W-1:0];
         sra_pkg::REG_ALPHA0: alphabet_words[0] = data;
         sra_pkg::REG_ALPHA1: alphabet_words[1] = data;
         sra_pkg::REG_ALPHA2: alphabet_words[2] = data;
         sra_pkg::REG_ALPHA3: alphabet_words[3] = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [sra_pkg::CSR_DATA_W-1:0] radix_data,
                                word_set_type words);
      drain_pending();
      write_csr(sra_pkg::REG_RADIX, radix_data);
      write_csr(sra_pkg::REG_ALPHA0, words[0]);
      write_csr(sra_pkg::REG_ALPHA1, words[1]);
      write_csr(sra_pkg::REG_ALPHA2, words[2]);
      write_csr(sra_pkg::REG_ALPHA3, words[3]);
      csr_write_enable <= 1'b0;
   endtask

   // present one item, leave start high after acceptance
   task automatic send_number(logic signed [VALUE_BITS-1:0] value);
      int gap;
      if (!steady_stream && $urandom_range(0, 99) < 33) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_number <= value;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_text(value);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // every way an alphabet can be rejected, plus ignored bytes past the radix and upper radix bits
   task automatic test_alphabet_rules();
      word_set_type w;
      logic [sra_pkg::CHAR_W-1:0] bad [6];
      bad = '{sra_pkg::CHAR_NUL, sra_pkg::CHAR_PLUS, sra_pkg::CHAR_MINUS,
              sra_pkg::CHAR_SPACE, sra_pkg::CHAR_TAB, sra_pkg::CHAR_CR};
      apply_setting(0, make_alphabet(sra_pkg::ALPHA_SLOTS));
      send_number(random_number());
      apply_setting(1, make_alphabet(sra_pkg::ALPHA_SLOTS));
      send_number(random_number());
      apply_setting(sra_pkg::ALPHA_SLOTS + 1, make_alphabet(sra_pkg::ALPHA_SLOTS));
      send_number(random_number());
      apply_setting({sra_pkg::CSR_DATA_W{1'b1}}, make_alphabet(sra_pkg::ALPHA_SLOTS));
      send_number(random_number());
      // forbidden characters inside the used range
      foreach (bad[k]) begin
         w = make_alphabet(16);
         w[k / 8][(k % 8) * 8 +: sra_pkg::CHAR_W] = bad[k];
         apply_setting(16, w);
         send_number(random_number());
      end
      // repeated character
      w = run_alphabet("a", 20);
      w[2][3 * 8 +: sra_pkg::CHAR_W] = "e";
      apply_setting(20, w);
      send_number(12345);
      // forbidden bytes above the radix are not looked at
      w = run_alphabet("0", 8);
      w[1] = {sra_pkg::CHAR_PLUS, sra_pkg::CHAR_MINUS, sra_pkg::CHAR_SPACE, sra_pkg::CHAR_TAB,
              sra_pkg::CHAR_CR, sra_pkg::CHAR_NUL, "0", "1"};
      apply_setting(8, w);
      send_number(-4095);
      // upper bits of the radix write are dropped
      apply_setting({{(sra_pkg::CSR_DATA_W-sra_pkg::RADIX_W){1'b1}}, sra_pkg::RADIX_W'(10)},
                    run_alphabet("0", 10));
      send_number(-987654);
   endtask

   task automatic test_value_extremes();
      logic signed [VALUE_BITS-1:0] int_min;
      logic signed [VALUE_BITS-1:0] int_max;
      int_min = {1'b1, {(VALUE_BITS-1){1'b0}}};
      int_max = {1'b0, {(VALUE_BITS-1){1'b1}}};
      apply_setting(10, run_alphabet("0", 10));
      send_number(0);
      send_number(1);
      send_number(-1);
      send_number(int_max);
      send_number(int_min);
      apply_setting(sra_pkg::RADIX_MIN, run_alphabet("0", 2));
      send_number(int_min);
      send_number(-1);
      send_number(int_max);
      // widest alphabet, high-bit characters
      apply_setting(sra_pkg::ALPHA_SLOTS, run_alphabet(8'hE0, sra_pkg::ALPHA_SLOTS));
      send_number(int_min);
      send_number(0);
      send_number(int_max);
   endtask

   task automatic test_random_settings();
      word_set_type w;
      int           n;
      int           i;
      int           j;
      int unsigned  pick;
      logic [sra_pkg::CSR_DATA_W-1:0] radix_data;
      for (int phase = 0; phase < 10; phase++) begin
         n = random_radix();
         w = make_alphabet(n);
         radix_data = {$urandom, $urandom};
         radix_data[sra_pkg::RADIX_W-1:0] = sra_pkg::RADIX_W'(n);
         pick = $urandom_range(0, 99);
         if (pick >= 80) begin
            case ($urandom_range(0, 3))
               0: radix_data[sra_pkg::RADIX_W-1:0] = sra_pkg::RADIX_W'($urandom_range(0, 1));
               1: radix_data[sra_pkg::RADIX_W-1:0] =
                     sra_pkg::RADIX_W'($urandom_range(sra_pkg::ALPHA_SLOTS + 1, 63));
               2: begin
                  i = $urandom_range(0, n - 1);
                  w[i / 8][(i % 8) * 8 +: sra_pkg::CHAR_W] = random_bad_char();
               end
               default: begin
                  i = $urandom_range(0, n - 2);
                  j = $urandom_range(i + 1, n - 1);
                  w[j / 8][(j % 8) * 8 +: sra_pkg::CHAR_W] =
                     w[i / 8][(i % 8) * 8 +: sra_pkg::CHAR_W];
               end
            endcase
         end
         apply_setting(radix_data, w);
         repeat (16) send_number(random_number());
      end
   endtask

   // back-to-back items with no idle cycles
   task automatic test_steady_stream();
      int n;
      n = random_radix();
      apply_setting(n, make_alphabet(n));
      steady_stream = 1'b1;
      repeat (40) send_number(random_number());
      steady_stream = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      text_byte_type want;
      if (!reset && rsp_valid) begin
         if (pending_text.size() == 0) begin
            report_mismatch($sformatf("unexpected item char %h last %b status %b",
                                      rsp_character, rsp_last, rsp_status));
         end else begin
            want = pending_text.pop_front();
            if (rsp_character !== want.character || rsp_last !== want.last ||
                rsp_status !== want.status)
               report_mismatch($sformatf(
                  "expected char %h last %b status %b, got char %h last %b status %b",
                  want.character, want.last, want.status,
                  rsp_character, rsp_last, rsp_status));
         end
      end
   end

   // watchdog on cycles with no progress on any port
   always @(posedge clock) begin
      if (reset || csr_write_enable || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_alphabet_rules();
      test_value_extremes();
      test_random_settings();
      test_steady_stream();
      drain_pending();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_text.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sra_pkg.sv
rtl/core/sra_ctrl.sv
rtl/core/sra_dpath.sv
rtl/core/signed_radix_to_ascii.sv
test/signed_radix_to_ascii_tb.sv
